[sv/cmba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmba_pkg
// Widths, operation codes, saturation limits and divider interface types for
// the common-mode bin averager.
// ----------------------------------------------------------------------------
package cmba_pkg;

   localparam int FUNC_W = 2;
   localparam int CHAN_W = 8;
   localparam int BIN_W  = 9;
   localparam int ADC_W  = 10;
   localparam int BASE_W = 14;
   localparam int CNT_W  = 9;
   localparam int CM_W   = 15;
   localparam int SUM_W  = 24;

   // pedestal entry: dead mark above the baseline
   localparam int PED_W    = BASE_W + 1;
   localparam int DEAD_BIT = BASE_W;

   // sample term: adc * 16 - baseline, signed
   localparam int TERM_W = ADC_W + 4 + 1;

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

   localparam logic signed [CM_W-1:0] CM_MAX = 15'sh3FFF;
   localparam logic signed [CM_W-1:0] CM_MIN = 15'sh4000;
   // quotient magnitudes at the saturation points
   localparam logic [SUM_W-1:0] CM_POS_LIM = 24'd16383;
   localparam logic [SUM_W-1:0] CM_NEG_LIM = 24'd16384;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] dividend;
      logic [CNT_W-1:0]        divisor;
      logic [BIN_W-1:0]        bin;
   } div_req_type;

   typedef struct packed {
      logic                   idle;
      logic                   valid;
      logic [BIN_W-1:0]       bin;
      logic signed [CM_W-1:0] quot;
   } div_rsp_type;

endpackage

[sv/cmba_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmba_div
// Bit-serial restoring divider: signed bin sum over unsigned channel count,
// truncated toward zero and saturated to the Q.4 output range.
// ----------------------------------------------------------------------------
module cmba_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cmba_pkg::div_req_type div_req,
   input  logic                  div_take,
   output cmba_pkg::div_rsp_type div_rsp
);
   import cmba_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_RUN  = 3'b010,
      DIV_DONE = 3'b100
   } div_state_type;

   div_state_type      state_ff, state_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   divisor_ff, divisor_in;
   logic               neg_ff, neg_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic [CNT_W:0]     trial;
   logic [CNT_W:0]     trial_diff;
   logic               ge;
   logic [SUM_W-1:0]   mag;
   logic [CM_W-1:0]    quo_low_neg;

   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign ge         = trial >= {1'b0, divisor_ff};
   assign mag        = div_req.dividend[SUM_W-1] ? (~div_req.dividend + 1'b1)
                                                 : div_req.dividend;
   assign quo_low_neg = ~quo_ff[CM_W-1:0] + 1'b1;

   always_comb begin
      state_in   = state_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      bin_in     = bin_ff;
      step_in    = step_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (div_req.start) begin
               quo_in     = mag;
               rem_in     = '0;
               divisor_in = div_req.divisor;
               neg_in     = div_req.dividend[SUM_W-1];
               bin_in     = div_req.bin;
               step_in    = STEP_W'(SUM_W - 1);
               state_in   = DIV_RUN;
            end
         end
         DIV_RUN: begin
            quo_in = {quo_ff[SUM_W-2:0], ge};
            rem_in = ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            if (step_ff == '0) begin
               state_in = DIV_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         DIV_DONE: begin
            if (div_take) begin
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      bin_ff     <= bin_in;
      step_ff    <= step_in;
   end

   always_comb begin
      div_rsp.idle  = state_ff == DIV_IDLE;
      div_rsp.valid = state_ff == DIV_DONE;
      div_rsp.bin   = bin_ff;
      if (neg_ff) begin
         div_rsp.quot = (quo_ff > CM_NEG_LIM) ? CM_MIN : signed'(quo_low_neg);
      end else begin
         div_rsp.quot = (quo_ff > CM_POS_LIM) ? CM_MAX : signed'(quo_ff[CM_W-1:0]);
      end
   end

endmodule

[sv/common_mode_bin_averager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// common_mode_bin_averager
// Per-time-bin common-mode estimator: pedestal table, per-bin running sums of
// baseline-subtracted samples, readout as sum / channel count in Q.4.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  req_    | in  | func, chan_index, time_bin, adc_sample, baseline_q4,
//          |     | dead_flag, chan_count
//  rsp_    | out | out_bin, common_mode_q4 (one per read-and-clear)
//
//  Pedestal loads and sample adds go one per cycle unless a readout stalls
//  them: both tables are read at acceptance and written back the next
//  cycle, with a bypass for the entry written at the same edge as the read.
//  A readout holds the divider for 24 quotient bits, one per cycle, and until
//  its result is taken; a following readout waits, other transactions do not.
//  After reset both tables are cleared, one entry per cycle, through the
//  depth of the deeper table while req_stall is high. A stalled result is
//  held; one more result may complete in the divider behind it.
// ----------------------------------------------------------------------------
module common_mode_bin_averager #(
   parameter int CHANNELS  = 256,
   parameter int TIME_BINS = 512,
   parameter int ADC_BITS  = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cmba_pkg::FUNC_W-1:0]          req_func,
   input  logic [cmba_pkg::CHAN_W-1:0]          req_chan_index,
   input  logic [cmba_pkg::BIN_W-1:0]           req_time_bin,
   input  logic [cmba_pkg::ADC_W-1:0]           req_adc_sample,
   input  logic [cmba_pkg::BASE_W-1:0]          req_baseline_q4,
   input  logic                                 req_dead_flag,
   input  logic [cmba_pkg::CNT_W-1:0]           req_chan_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cmba_pkg::BIN_W-1:0]           rsp_out_bin,
   output logic signed [cmba_pkg::CM_W-1:0]     rsp_common_mode_q4
);
   import cmba_pkg::*;

   localparam int PED_DEPTH = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
   localparam int BIN_DEPTH = (TIME_BINS < (1 << BIN_W)) ? TIME_BINS : (1 << BIN_W);
   localparam int PED_AW    = $clog2(PED_DEPTH);
   localparam int BIN_AW    = $clog2(BIN_DEPTH);
   localparam int CLR_DEPTH = (PED_DEPTH > BIN_DEPTH) ? PED_DEPTH : BIN_DEPTH;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int ADC_KEEP  = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
   localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((32'd1 << ADC_KEEP) - 32'd1);

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CLR_W-1:0]        clr_cnt_ff, clr_cnt_in;
   logic                    clearing;

   logic                    accept;
   logic                    fire;

   // stage holding the transaction whose table reads are in flight
   logic                    s1_valid_ff, s1_valid_in;
   logic [FUNC_W-1:0]       s1_func_ff;
   logic [PED_AW-1:0]       s1_chan_ff;
   logic [BIN_AW-1:0]       s1_bin_idx_ff;
   logic [BIN_W-1:0]        s1_bin_ff;
   logic [ADC_W-1:0]        s1_adc_ff;
   logic [BASE_W-1:0]       s1_base_ff;
   logic                    s1_dead_ff;
   logic [CNT_W-1:0]        s1_cnt_ff;
   logic                    s1_chan_ok_ff;
   logic                    s1_bin_ok_ff;

   logic [PED_W-1:0]        ped_mem [PED_DEPTH];
   logic signed [SUM_W-1:0] bin_mem [BIN_DEPTH];
   logic [PED_W-1:0]        ped_rd_ff;
   logic signed [SUM_W-1:0] bin_rd_ff;

   logic                    ped_we;
   logic [PED_AW-1:0]       ped_waddr;
   logic [PED_W-1:0]        ped_wdata;
   logic                    bin_we;
   logic [BIN_AW-1:0]       bin_waddr;
   logic signed [SUM_W-1:0] bin_wdata;

   logic                    byp_ped_v_ff;
   logic [PED_AW-1:0]       byp_ped_addr_ff;
   logic [PED_W-1:0]        byp_ped_data_ff;
   logic                    byp_bin_v_ff;
   logic [BIN_AW-1:0]       byp_bin_addr_ff;
   logic signed [SUM_W-1:0] byp_bin_data_ff;

   logic [PED_W-1:0]        ped_cur;
   logic signed [SUM_W-1:0] bin_cur;
   logic signed [TERM_W-1:0] term;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_sat;
   logic                    add_ok;

   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic                    div_take;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]        rsp_bin_ff;
   logic signed [CM_W-1:0]  rsp_cm_ff;

   // ---------------------------------------------------------------- control
   assign clearing  = state_ff == ST_CLEAR;
   assign fire      = s1_valid_ff && ((s1_func_ff != FUNC_READ) || div_rsp.idle);
   assign req_stall = clearing || (s1_valid_ff && !fire);
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in = accept || (s1_valid_ff && !fire);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN:  state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff    <= req_func;
         s1_chan_ff    <= req_chan_index[PED_AW-1:0];
         s1_bin_idx_ff <= req_time_bin[BIN_AW-1:0];
         s1_bin_ff     <= req_time_bin;
         s1_adc_ff     <= req_adc_sample & ADC_MASK;
         s1_base_ff    <= req_baseline_q4;
         s1_dead_ff    <= req_dead_flag;
         s1_cnt_ff     <= req_chan_count;
         s1_chan_ok_ff <= 32'(req_chan_index) < CHANNELS;
         s1_bin_ok_ff  <= 32'(req_time_bin) < TIME_BINS;
      end
   end

   // ---------------------------------------------------------------- tables
   always_ff @(posedge clock) begin
      if (ped_we) begin
         ped_mem[ped_waddr] <= ped_wdata;
      end
      if (accept) begin
         ped_rd_ff <= ped_mem[req_chan_index[PED_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      if (accept) begin
         bin_rd_ff <= bin_mem[req_time_bin[BIN_AW-1:0]];
      end
   end

   // a write at the read edge is missed by the read; keep it for the bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ped_v_ff <= 1'b0;
         byp_bin_v_ff <= 1'b0;
      end else if (accept) begin
         byp_ped_v_ff <= ped_we;
         byp_bin_v_ff <= bin_we;
      end
      if (accept) begin
         byp_ped_addr_ff <= ped_waddr;
         byp_ped_data_ff <= ped_wdata;
         byp_bin_addr_ff <= bin_waddr;
         byp_bin_data_ff <= bin_wdata;
      end
   end

   assign ped_cur = (byp_ped_v_ff && (byp_ped_addr_ff == s1_chan_ff))
                    ? byp_ped_data_ff : ped_rd_ff;
   assign bin_cur = (byp_bin_v_ff && (byp_bin_addr_ff == s1_bin_idx_ff))
                    ? byp_bin_data_ff : bin_rd_ff;

   // ---------------------------------------------------------------- datapath
   assign term     = signed'({1'b0, s1_adc_ff, 4'b0000})
                   - signed'({1'b0, ped_cur[BASE_W-1:0]});
   assign sum_wide = {bin_cur[SUM_W-1], bin_cur}
                   + {{(SUM_W + 1 - TERM_W){term[TERM_W-1]}}, term};
   assign sum_sat  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                     ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX)
                     : sum_wide[SUM_W-1:0];
   assign add_ok   = s1_chan_ok_ff && s1_bin_ok_ff && (s1_adc_ff != '0)
                     && !ped_cur[DEAD_BIT];

   always_comb begin
      ped_we           = 1'b0;
      ped_waddr        = s1_chan_ff;
      ped_wdata        = {s1_dead_ff, s1_base_ff};
      bin_we           = 1'b0;
      bin_waddr        = s1_bin_idx_ff;
      bin_wdata        = '0;
      div_req.start    = 1'b0;
      div_req.dividend = (s1_bin_ok_ff && (s1_cnt_ff != '0)) ? bin_cur : '0;
      div_req.divisor  = (s1_cnt_ff == '0) ? CNT_W'(1) : s1_cnt_ff;
      div_req.bin      = s1_bin_ff;
      if (clearing) begin
         ped_we    = 32'(clr_cnt_ff) < PED_DEPTH;
         ped_waddr = clr_cnt_ff[PED_AW-1:0];
         ped_wdata = '0;
         bin_we    = 32'(clr_cnt_ff) < BIN_DEPTH;
         bin_waddr = clr_cnt_ff[BIN_AW-1:0];
      end else if (fire) begin
         unique case (s1_func_ff)
            FUNC_LOAD: ped_we = s1_chan_ok_ff;
            FUNC_ADD: begin
               bin_we    = add_ok;
               bin_wdata = sum_sat;
            end
            FUNC_READ: begin
               bin_we        = s1_bin_ok_ff;
               div_req.start = 1'b1;
            end
            default: ;
         endcase
      end
   end

   cmba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_take (div_take),
      .div_rsp  (div_rsp)
   );

   // ---------------------------------------------------------------- output
   assign div_take     = div_rsp.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = div_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (div_take) begin
         rsp_bin_ff <= div_rsp.bin;
         rsp_cm_ff  <= div_rsp.quot;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_bin        = rsp_bin_ff;
   assign rsp_common_mode_q4 = rsp_cm_ff;

   // ---------------------------------------------------------------- checks
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> div_rsp.idle)
      else $error("divider started while busy");

   a_div_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_rsp.idle)
      else $error("divider did not take a readout");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid_ff && !s1_valid_ff)
      else $error("activity during table clear");

   a_take_needs_result: assert property (@(posedge clock) disable iff (reset)
      div_take |-> div_rsp.valid && !clearing)
      else $error("result taken from idle divider");

endmodule
